FILE: hw/rtl/xec_pkg.sv
// shared types, entity tables and match functions for the xml entity codec
`timescale 1ns / 1ps

package xec_pkg;

  localparam int NUM_ENT   = 5;
  localparam int HOLD_MAX  = 5;
  localparam int JOB_BYTES = 6;
  localparam int CNT_W     = 3;

  localparam logic [7:0] CH_AMP  = 8'h26;
  localparam logic [7:0] CH_LT   = 8'h3C;
  localparam logic [7:0] CH_GT   = 8'h3E;
  localparam logic [7:0] CH_QUOT = 8'h22;
  localparam logic [7:0] CH_APOS = 8'h27;
  localparam logic [7:0] CH_SEMI = 8'h3B;

  localparam logic MODE_ESCAPE   = 1'b0;
  localparam logic MODE_UNESCAPE = 1'b1;

  typedef logic [7:0]                  byte_t;
  typedef logic [CNT_W-1:0]            cnt_t;
  typedef logic [JOB_BYTES-1:0][7:0]   text_t;
  typedef logic [HOLD_MAX-1:0][7:0]    hold_t;

  typedef enum logic [2:0] {
    ENT_AMP,
    ENT_LT,
    ENT_GT,
    ENT_QUOT,
    ENT_APOS
  } ent_t;

  // one queued unit of output: cnt bytes, last flags the final one
  typedef struct packed {
    text_t bytes;
    cnt_t  cnt;
    logic  last;
  } job_t;

  typedef struct packed {
    logic  hit;
    byte_t ch;
  } match_t;

  // entity text, first byte at index 0
  function automatic text_t ent_text(input ent_t e);
    text_t t;
    unique case (e)
      ENT_AMP:  t = {8'h00, CH_SEMI, "p", "m", "a", CH_AMP};
      ENT_LT:   t = {8'h00, 8'h00, CH_SEMI, "t", "l", CH_AMP};
      ENT_GT:   t = {8'h00, 8'h00, CH_SEMI, "t", "g", CH_AMP};
      ENT_QUOT: t = {CH_SEMI, "t", "o", "u", "q", CH_AMP};
      ENT_APOS: t = {CH_SEMI, "s", "o", "p", "a", CH_AMP};
      default:  t = '0;
    endcase
    return t;
  endfunction

  function automatic cnt_t ent_len(input ent_t e);
    cnt_t n;
    unique case (e)
      ENT_AMP:  n = cnt_t'(5);
      ENT_LT:   n = cnt_t'(4);
      ENT_GT:   n = cnt_t'(4);
      ENT_QUOT: n = cnt_t'(6);
      ENT_APOS: n = cnt_t'(6);
      default:  n = '0;
    endcase
    return n;
  endfunction

  function automatic byte_t ent_char(input ent_t e);
    byte_t c;
    unique case (e)
      ENT_AMP:  c = CH_AMP;
      ENT_LT:   c = CH_LT;
      ENT_GT:   c = CH_GT;
      ENT_QUOT: c = CH_QUOT;
      ENT_APOS: c = CH_APOS;
      default:  c = '0;
    endcase
    return c;
  endfunction

  // held bytes agree with the entity text over the first p positions
  function automatic logic prefix_ok(input hold_t pend, input cnt_t p, input ent_t e);
    logic  ok;
    text_t t;
    ok = 1'b1;
    t  = ent_text(e);
    for (int i = 0; i < HOLD_MAX; i++) begin
      if ((cnt_t'(i) < p) && (pend[i] != t[i])) ok = 1'b0;
    end
    return ok;
  endfunction

  // held bytes plus b still start some entity, not counting its ';'
  function automatic logic still_prefix(input hold_t pend, input cnt_t p, input byte_t b);
    logic  hit;
    text_t t;
    ent_t  e;
    hit = 1'b0;
    for (int k = 0; k < NUM_ENT; k++) begin
      e = ent_t'(k);
      t = ent_text(e);
      if ((({1'b0, p} + 4'd2) <= {1'b0, ent_len(e)}) && prefix_ok(pend, p, e) &&
          (t[p] == b)) hit = 1'b1;
    end
    return hit;
  endfunction

  // entity closed by a ';' after the held bytes
  function automatic match_t complete_entity(input hold_t pend, input cnt_t p);
    match_t m;
    ent_t   e;
    m = '0;
    for (int k = NUM_ENT - 1; k >= 0; k--) begin
      e = ent_t'(k);
      if ((({1'b0, p} + 4'd1) == {1'b0, ent_len(e)}) && prefix_ok(pend, p, e)) begin
        m.hit = 1'b1;
        m.ch  = ent_char(e);
      end
    end
    return m;
  endfunction

endpackage

FILE: hw/rtl/xml_entity_codec_core.sv
// top level of the xml predefined entity escape/unescape codec
`timescale 1ns / 1ps

// Byte stream codec for the five predefined XML entities; cfg_data selects
// escape (0) or unescape (1) and writing it drops any held entity bytes.
// A byte is taken every cycle while full is low. The front end turns each
// byte into a job of zero to six output bytes and places it in a two-entry
// job queue; the back end sends one output byte per cycle, while pop is
// high, from its job register, so an expanded byte leaves more slowly than
// it came in and the queue absorbs the difference. A result passes through
// the job queue and then the job register before it shows on the outputs.
// In unescape mode bytes after '&' are held (no output) until an entity
// completes, fails, or the record ends.

module xml_entity_codec_core (
  input  logic       clk,
  input  logic       rst_n,
  input  logic       cfg_we,
  input  logic       cfg_data,
  input  logic       push,
  output logic       full,
  input  logic [7:0] in_byte,
  input  logic       in_last,
  output logic       empty,
  input  logic       pop,
  output logic [7:0] out_byte,
  output logic       out_last
);
  import xec_pkg::*;

  job_t front_job;
  job_t q_job;
  logic job_push;
  logic q_full;
  logic q_empty;
  logic q_pop;
  logic accept;

  assign full   = q_full;
  assign accept = push && !q_full;

  // classify and build jobs
  xec_front u_front (
    .clk      (clk),
    .rst_n    (rst_n),
    .cfg_we   (cfg_we),
    .cfg_data (cfg_data),
    .accept   (accept),
    .in_byte  (in_byte),
    .in_last  (in_last),
    .job_push (job_push),
    .job      (front_job)
  );

  // job queue
  xec_fifo u_fifo (
    .clk     (clk),
    .rst_n   (rst_n),
    .wr_en   (job_push),
    .wr_job  (front_job),
    .rd_en   (q_pop),
    .rd_job  (q_job),
    .q_full  (q_full),
    .q_empty (q_empty)
  );

  // serialize jobs to output bytes
  xec_back u_back (
    .clk      (clk),
    .rst_n    (rst_n),
    .q_job    (q_job),
    .q_empty  (q_empty),
    .q_pop    (q_pop),
    .pop      (pop),
    .empty    (empty),
    .out_byte (out_byte),
    .out_last (out_last)
  );

endmodule

FILE: hw/rtl/xec_front.sv
// front end: accepts bytes, tracks pending entity bytes, builds output jobs
`timescale 1ns / 1ps

module xec_front (
  input  logic           clk,
  input  logic           rst_n,
  input  logic           cfg_we,
  input  logic           cfg_data,
  input  logic           accept,
  input  logic [7:0]     in_byte,
  input  logic           in_last,
  output logic           job_push,
  output xec_pkg::job_t  job
);
  import xec_pkg::*;

  logic   mode_r;
  hold_t  pend_r;
  cnt_t   pend_cnt_r;
  cnt_t   pend_cnt_nxt;

  logic   emit_old;
  logic   emit_x;
  byte_t  x;
  logic   wr_amp;
  logic   wr_slot;
  match_t done;
  logic   grow;
  logic   esc_hit;
  ent_t   esc_ent;

  // special byte lookup for escape mode
  always_comb begin
    esc_hit = 1'b1;
    unique case (in_byte)
      CH_AMP:  esc_ent = ENT_AMP;
      CH_LT:   esc_ent = ENT_LT;
      CH_GT:   esc_ent = ENT_GT;
      CH_QUOT: esc_ent = ENT_QUOT;
      CH_APOS: esc_ent = ENT_APOS;
      default: begin
        esc_ent = ENT_AMP;
        esc_hit = 1'b0;
      end
    endcase
  end

  assign done = complete_entity(pend_r, pend_cnt_r);
  assign grow = (pend_cnt_r < cnt_t'(HOLD_MAX)) && still_prefix(pend_r, pend_cnt_r, in_byte);

  // unescape decision: flush held bytes, then at most one more byte
  always_comb begin
    emit_old     = 1'b0;
    emit_x       = 1'b0;
    x            = in_byte;
    wr_amp       = 1'b0;
    wr_slot      = 1'b0;
    pend_cnt_nxt = '0;
    if (pend_cnt_r == '0) begin
      if (in_byte == CH_AMP) begin
        wr_amp       = 1'b1;
        pend_cnt_nxt = cnt_t'(1);
        if (in_last) begin
          emit_x       = 1'b1;
          pend_cnt_nxt = '0;
        end
      end else begin
        emit_x = 1'b1;
      end
    end else if (in_byte == CH_AMP) begin
      emit_old     = 1'b1;
      wr_amp       = 1'b1;
      pend_cnt_nxt = cnt_t'(1);
      if (in_last) begin
        emit_x       = 1'b1;
        pend_cnt_nxt = '0;
      end
    end else if (in_byte == CH_SEMI) begin
      emit_x = 1'b1;
      if (done.hit) begin
        x = done.ch;
      end else begin
        emit_old = 1'b1;
      end
    end else if (grow) begin
      wr_slot      = 1'b1;
      pend_cnt_nxt = pend_cnt_r + cnt_t'(1);
      if (in_last) begin
        emit_old     = 1'b1;
        emit_x       = 1'b1;
        pend_cnt_nxt = '0;
      end
    end else begin
      emit_old = 1'b1;
      emit_x   = 1'b1;
    end
  end

  // job assembly
  always_comb begin
    job.last = in_last;
    if (mode_r == MODE_ESCAPE) begin
      if (esc_hit) begin
        job.bytes = ent_text(esc_ent);
        job.cnt   = ent_len(esc_ent);
      end else begin
        job.bytes = '0;
        job.bytes[0] = in_byte;
        job.cnt   = cnt_t'(1);
      end
    end else begin
      for (int i = 0; i < JOB_BYTES; i++) job.bytes[i] = x;
      for (int i = 0; i < HOLD_MAX; i++) begin
        if (emit_old && (cnt_t'(i) < pend_cnt_r)) job.bytes[i] = pend_r[i];
      end
      job.cnt = (emit_old ? pend_cnt_r : cnt_t'(0)) + cnt_t'(emit_x);
    end
  end

  assign job_push = accept && (job.cnt != '0);

  // mode and pending count
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      mode_r     <= MODE_ESCAPE;
      pend_cnt_r <= '0;
    end else if (cfg_we) begin
      mode_r     <= cfg_data;
      pend_cnt_r <= '0;
    end else if (accept && (mode_r == MODE_UNESCAPE)) begin
      pend_cnt_r <= pend_cnt_nxt;
    end
  end

  // pending bytes
  always_ff @(posedge clk) begin
    if (accept && (mode_r == MODE_UNESCAPE)) begin
      if (wr_amp) pend_r[0] <= CH_AMP;
      if (wr_slot) pend_r[pend_cnt_r] <= in_byte;
    end
  end

endmodule

FILE: hw/rtl/xec_fifo.sv
// two-entry job queue between front and back
`timescale 1ns / 1ps

module xec_fifo (
  input  logic           clk,
  input  logic           rst_n,
  input  logic           wr_en,
  input  xec_pkg::job_t  wr_job,
  input  logic           rd_en,
  output xec_pkg::job_t  rd_job,
  output logic           q_full,
  output logic           q_empty
);
  import xec_pkg::*;

  job_t       mem_r [2];
  logic       wr_ptr_r;
  logic       rd_ptr_r;
  logic [1:0] fill_r;
  logic       do_wr;
  logic       do_rd;

  assign q_full  = (fill_r == 2'd2);
  assign q_empty = (fill_r == 2'd0);
  assign rd_job  = mem_r[rd_ptr_r];
  assign do_wr   = wr_en && !q_full;
  assign do_rd   = rd_en && !q_empty;

  // pointers and fill level
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      wr_ptr_r <= 1'b0;
      rd_ptr_r <= 1'b0;
      fill_r   <= 2'd0;
    end else begin
      if (do_wr) wr_ptr_r <= !wr_ptr_r;
      if (do_rd) rd_ptr_r <= !rd_ptr_r;
      fill_r <= fill_r + 2'(do_wr) - 2'(do_rd);
    end
  end

  // storage
  always_ff @(posedge clk) begin
    if (do_wr) mem_r[wr_ptr_r] <= wr_job;
  end

endmodule

FILE: hw/rtl/xec_back.sv
// back end: walks the current job one output byte per cycle while pop is high
`timescale 1ns / 1ps

module xec_back (
  input  logic           clk,
  input  logic           rst_n,
  input  xec_pkg::job_t  q_job,
  input  logic           q_empty,
  output logic           q_pop,
  input  logic           pop,
  output logic           empty,
  output logic [7:0]     out_byte,
  output logic           out_last
);
  import xec_pkg::*;

  job_t cur_r;
  cnt_t idx_r;
  logic valid_r;
  logic at_end;
  logic take;

  assign at_end   = (idx_r == (cur_r.cnt - cnt_t'(1)));
  assign take     = valid_r && pop;
  assign q_pop    = !q_empty && (!valid_r || (take && at_end));
  assign empty    = !valid_r;
  assign out_byte = cur_r.bytes[idx_r];
  assign out_last = cur_r.last && at_end;

  // current job control
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      valid_r <= 1'b0;
      idx_r   <= '0;
    end else if (q_pop) begin
      valid_r <= 1'b1;
      idx_r   <= '0;
    end else if (take) begin
      if (at_end) begin
        valid_r <= 1'b0;
      end else begin
        idx_r <= idx_r + cnt_t'(1);
      end
    end
  end

  // current job payload
  always_ff @(posedge clk) begin
    if (q_pop) cur_r <= q_job;
  end

endmodule

FILE: hw/rtl/xec_checker.sv
// port-level checker for the xml entity codec, bound to the top level
`timescale 1ns / 1ps

module xec_checker (
  input logic       clk,
  input logic       rst_n,
  input logic       push,
  input logic       full,
  input logic       empty,
  input logic       pop,
  input logic [7:0] out_byte,
  input logic       out_last
);

  // reset leaves no item waiting at the output
  a_reset_empty: assert property (@(posedge clk) !rst_n |=> empty)
    else $error("output not empty after reset");

  // reset leaves the input side open
  a_reset_open: assert property (@(posedge clk) !rst_n |=> !full)
    else $error("input full after reset");

  // a waiting item that is not taken stays put
  a_out_hold: assert property (@(posedge clk) disable iff (!rst_n)
    (!empty && !pop) |=> (!empty && $stable(out_byte) && $stable(out_last)))
    else $error("waiting output item changed");

  // full only rises after an input item was taken
  a_full_cause: assert property (@(posedge clk) disable iff (!rst_n)
    (!full && !push) |=> !full)
    else $error("full rose without an input item");

endmodule

bind xml_entity_codec_core xec_checker u_chk (.*);

FILE: tb/tb_xml_entity_codec_core.sv
// self-checking testbench for the xml entity escape/unescape codec core
`timescale 1ns / 1ps

module tb_xml_entity_codec_core;
  import xec_pkg::*;

  // one expected output byte
  typedef struct packed {
    byte_t data;
    logic  last;
  } res_t;

  typedef enum logic {ROW_ITEM, ROW_MODE} row_kind_t;

  // directed row: want holds the typed output text, zero means use the predictor
  typedef struct packed {
    row_kind_t   kind;
    byte_t       data;
    logic        last;
    logic [47:0] want;
  } row_t;

  localparam int NUM_ROWS = 28;

  logic       clk      = 1'b0;
  logic       rst_n    = 1'b0;
  logic       cfg_we   = 1'b0;
  logic       cfg_data = 1'b0;
  logic       push     = 1'b0;
  logic [7:0] in_byte  = 8'h00;
  logic       in_last  = 1'b0;
  logic       pop      = 1'b0;
  logic       full;
  logic       empty;
  logic [7:0] out_byte;
  logic       out_last;

  // predictor state
  logic  mode_q = MODE_ESCAPE;
  byte_t held [HOLD_MAX];
  int    held_n = 0;
  res_t  step_q [$];
  res_t  want_q [$];

  string ent_txt [NUM_ENT] = '{"&amp;", "&lt;", "&gt;", "&quot;", "&apos;"};
  byte_t ent_val [NUM_ENT] = '{CH_AMP, CH_LT, CH_GT, CH_QUOT, CH_APOS};
  string letters = "amplgtquos";

  int  err_count  = 0;
  int  n_items    = 0;
  int  n_checked  = 0;
  int  n_writes   = 0;
  int  idle_odds  = 3;
  int  pop_hold   = 0;
  bit  quiet      = 1'b0;

  row_t dir_rows [NUM_ROWS] = '{
    '{ROW_ITEM, 8'h00,   1'b0, 48'h0},
    '{ROW_ITEM, 8'hFF,   1'b0, 48'h0},
    '{ROW_ITEM, CH_AMP,  1'b0, "&amp;"},
    '{ROW_ITEM, CH_LT,   1'b0, "&lt;"},
    '{ROW_ITEM, CH_GT,   1'b0, "&gt;"},
    '{ROW_ITEM, CH_QUOT, 1'b0, "&quot;"},
    '{ROW_ITEM, CH_APOS, 1'b1, "&apos;"},
    '{ROW_MODE, byte_t'(MODE_UNESCAPE), 1'b0, 48'h0},
    '{ROW_ITEM, CH_AMP,  1'b0, 48'h0},
    '{ROW_ITEM, "q",     1'b0, 48'h0},
    '{ROW_ITEM, "u",     1'b0, 48'h0},
    '{ROW_ITEM, "o",     1'b0, 48'h0},
    '{ROW_ITEM, "t",     1'b0, 48'h0},
    '{ROW_ITEM, CH_SEMI, 1'b0, "\""},
    // semicolon that closes no entity
    '{ROW_ITEM, CH_AMP,  1'b0, 48'h0},
    '{ROW_ITEM, CH_SEMI, 1'b0, "&;"},
    // second ampersand restarts the hold
    '{ROW_ITEM, CH_AMP,  1'b0, 48'h0},
    '{ROW_ITEM, "a",     1'b0, 48'h0},
    '{ROW_ITEM, CH_AMP,  1'b0, "&a"},
    '{ROW_ITEM, "q",     1'b0, 48'h0},
    '{ROW_ITEM, "?",     1'b0, "&q?"},
    // record ends while holding
    '{ROW_ITEM, CH_AMP,  1'b0, 48'h0},
    '{ROW_ITEM, "a",     1'b0, 48'h0},
    '{ROW_ITEM, "p",     1'b1, "&ap"},
    // mode write drops the held bytes
    '{ROW_ITEM, CH_AMP,  1'b0, 48'h0},
    '{ROW_ITEM, "l",     1'b0, 48'h0},
    '{ROW_MODE, byte_t'(MODE_ESCAPE), 1'b0, 48'h0},
    '{ROW_ITEM, "x",     1'b1, "x"}
  };

  xml_entity_codec_core uut (
    .clk      (clk),
    .rst_n    (rst_n),
    .cfg_we   (cfg_we),
    .cfg_data (cfg_data),
    .push     (push),
    .full     (full),
    .in_byte  (in_byte),
    .in_last  (in_last),
    .empty    (empty),
    .pop      (pop),
    .out_byte (out_byte),
    .out_last (out_last)
  );

  always #1 clk = ~clk;

  task automatic flag_error(input string msg);
    $display("MISMATCH at %0t ns: %s", $time, msg);
    err_count++;
  endtask

  // ---------------------------------------------------------------
  // predictor
  // ---------------------------------------------------------------
  function automatic void emit(input byte_t b);
    res_t r;
    r.data = b;
    r.last = 1'b0;
    step_q = {step_q, r};
  endfunction

  function automatic void spill_held();
    for (int i = 0; i < held_n; i++) emit(held[i]);
    held_n = 0;
  endfunction

  // held bytes agree with entity k over the held length
  function automatic bit held_matches(input int k);
    bit ok;
    ok = 1'b1;
    for (int i = 0; i < held_n; i++)
      if (held[i] != byte_t'(ent_txt[k][i])) ok = 1'b0;
    return ok;
  endfunction

  // held bytes plus b still start some entity, its ';' not counted
  function automatic bit extends_entity(input byte_t b);
    int m;
    m = held_n + 1;
    for (int k = 0; k < NUM_ENT; k++) begin
      if (m > ent_txt[k].len() - 1) continue;
      if (held_matches(k) && byte_t'(ent_txt[k][m-1]) == b) return 1'b1;
    end
    return 1'b0;
  endfunction

  // entity closed by a ';' after the held bytes, -1 if none
  function automatic int closed_entity();
    for (int k = 0; k < NUM_ENT; k++)
      if (held_n + 1 == ent_txt[k].len() && held_matches(k)) return k;
    return -1;
  endfunction

  function automatic void codec_step(input byte_t b, input logic last);
    int hit;
    step_q.delete();
    if (mode_q == MODE_ESCAPE) begin
      hit = -1;
      for (int k = 0; k < NUM_ENT; k++)
        if (ent_val[k] == b) hit = k;
      if (hit < 0) emit(b);
      else for (int i = 0; i < ent_txt[hit].len(); i++) emit(byte_t'(ent_txt[hit][i]));
    end else if (held_n == 0) begin
      if (b == CH_AMP) begin
        held[0] = b;
        held_n  = 1;
      end else emit(b);
    end else if (b == CH_AMP) begin
      spill_held();
      held[0] = b;
      held_n  = 1;
    end else if (b == CH_SEMI) begin
      hit = closed_entity();
      if (hit >= 0) begin
        emit(ent_val[hit]);
        held_n = 0;
      end else begin
        spill_held();
        emit(b);
      end
    end else if (held_n < HOLD_MAX && extends_entity(b)) begin
      held[held_n] = b;
      held_n++;
    end else begin
      spill_held();
      emit(b);
    end
    // end of record flushes and marks the final byte
    if (last) begin
      spill_held();
      if (step_q.size() > 0) step_q[step_q.size()-1].last = 1'b1;
    end
  endfunction

  // ---------------------------------------------------------------
  // sender side
  // ---------------------------------------------------------------
  task automatic send_item(input byte_t b, input logic last, input logic [47:0] want);
    int   n;
    res_t r;
    push    <= 1'b1;
    in_byte <= b;
    in_last <= last;
    @(posedge clk);
    while (full) @(posedge clk);
    n_items++;
    codec_step(b, last);
    if (want == 48'h0) begin
      want_q = {want_q, step_q};
    end else begin
      n = 0;
      for (int i = 0; i < 6; i++) if (want[8*i +: 8] != 8'h00) n = i + 1;
      for (int i = n - 1; i >= 0; i--) begin
        r.data = want[8*i +: 8];
        r.last = (i == 0) && last;
        want_q = {want_q, r};
      end
    end
    // random sender gap
    if (idle_odds != 0 && $urandom_range(1, idle_odds) == 1) begin
      push <= 1'b0;
      repeat ($urandom_range(1, 15)) @(posedge clk);
    end
  endtask

  // let every expected item arrive, then give held work time to settle
  task automatic drain_outputs();
    push <= 1'b0;
    while (want_q.size() != 0) @(posedge clk);
    repeat (8) @(posedge clk);
  endtask

  task automatic write_mode(input logic m);
    drain_outputs();
    cfg_we   <= 1'b1;
    cfg_data <= m;
    @(posedge clk);
    cfg_we   <= 1'b0;
    mode_q = m;
    held_n = 0;
    n_writes++;
  endtask

  // escape traffic, biased toward the special bytes
  task automatic send_escape_mix(input int count);
    byte_t b;
    for (int i = 0; i < count; i++) begin
      if ($urandom_range(0, 3) == 0) b = ent_val[$urandom_range(0, NUM_ENT - 1)];
      else b = byte_t'($urandom_range(0, 255));
      send_item(b, $urandom_range(0, 9) == 0, 48'h0);
    end
  endtask

  // unescape traffic: mostly entities, some cut short, plus noise bytes
  task automatic send_unescape_mix(input int count);
    int    k;
    int    cut;
    int    sent;
    byte_t b;
    sent = 0;
    while (sent < count) begin
      case ($urandom_range(0, 9))
        0, 1, 2, 3, 4: begin
          k   = $urandom_range(0, NUM_ENT - 1);
          cut = ent_txt[k].len();
          if ($urandom_range(0, 3) == 0) cut = $urandom_range(1, ent_txt[k].len() - 1);
          for (int i = 0; i < cut; i++) begin
            send_item(byte_t'(ent_txt[k][i]), $urandom_range(0, 11) == 0, 48'h0);
            sent++;
          end
          if (cut < ent_txt[k].len()) begin
            send_item(byte_t'($urandom_range(0, 255)), 1'b0, 48'h0);
            sent++;
          end
        end
        5: begin
          send_item(CH_AMP, $urandom_range(0, 11) == 0, 48'h0);
          sent++;
        end
        6: begin
          send_item(CH_SEMI, $urandom_range(0, 11) == 0, 48'h0);
          sent++;
        end
        7: begin
          b = byte_t'(letters[$urandom_range(0, letters.len() - 1)]);
          send_item(b, $urandom_range(0, 11) == 0, 48'h0);
          sent++;
        end
        default: begin
          send_item(byte_t'($urandom_range(0, 255)), $urandom_range(0, 11) == 0, 48'h0);
          sent++;
        end
      endcase
    end
  endtask

  // ---------------------------------------------------------------
  // result side: check each popped item, stall pop in random bursts
  // ---------------------------------------------------------------
  always @(posedge clk) begin
    res_t w;
    if (rst_n && pop && !empty) begin
      if (want_q.size() == 0) begin
        flag_error($sformatf("unexpected output byte %02h last %0b", out_byte, out_last));
      end else begin
        w = want_q.pop_front();
        n_checked++;
        if (out_byte !== w.data)
          flag_error($sformatf("out_byte %02h, wanted %02h", out_byte, w.data));
        if (out_last !== w.last)
          flag_error($sformatf("out_last %0b, wanted %0b (byte %02h)", out_last, w.last,
                               w.data));
      end
    end
    if (quiet) begin
      pop <= 1'b1;
    end else if (pop_hold > 0) begin
      pop_hold--;
      pop <= 1'b0;
    end else if ($urandom_range(0, 11) == 0) begin
      pop_hold = $urandom_range(0, 14);
      pop <= 1'b0;
    end else begin
      pop <= 1'b1;
    end
  end

  // ---------------------------------------------------------------
  // main sequence
  // ---------------------------------------------------------------
  initial begin
    repeat (4) @(posedge clk);
    rst_n <= 1'b1;
    @(posedge clk);

    // directed rows
    foreach (dir_rows[i]) begin
      if (dir_rows[i].kind == ROW_MODE) write_mode(dir_rows[i].data[0]);
      else send_item(dir_rows[i].data, dir_rows[i].last, dir_rows[i].want);
    end

    // random phases over both modes
    idle_odds = 6;
    write_mode(MODE_UNESCAPE);
    send_unescape_mix(50);

    idle_odds = 0;
    write_mode(MODE_ESCAPE);
    send_escape_mix(40);

    // sender holds off mid-phase until the output side is empty
    idle_odds = 4;
    write_mode(MODE_UNESCAPE);
    send_unescape_mix(30);
    drain_outputs();
    send_unescape_mix(30);

    idle_odds = 5;
    write_mode(MODE_ESCAPE);
    send_escape_mix(40);

    // closing stretch with no idling on either side
    idle_odds = 0;
    write_mode(MODE_UNESCAPE);
    quiet = 1'b1;
    send_unescape_mix(70);

    drain_outputs();
    repeat (10) @(posedge clk);

    $display("Covered %0d input items in both modes across %0d mode writes,",
             n_items, n_writes);
    $display("%0d output bytes checked", n_checked);
    if (err_count == 0) $display("Regression PASS");
    else $display("Regression FAIL");
    $finish;
  end

  // watchdog
  initial begin
    #400000;
    $display("Regression FAIL");
    $finish;
  end

endmodule

FILE: sim.f
hw/rtl/xec_pkg.sv
hw/rtl/xec_front.sv
hw/rtl/xec_fifo.sv
hw/rtl/xec_back.sv
hw/rtl/xml_entity_codec_core.sv
hw/rtl/xec_checker.sv
tb/tb_xml_entity_codec_core.sv
